@@ design/cddt_pkg.sv @@
package cddt_pkg;

    // tick limit bounds and default
    localparam logic [15:0] LIMIT_DEFAULT = 16'd31250;
    localparam logic [15:0] LIMIT_MAX     = 16'd40000;
    localparam logic [15:0] LIMIT_MIN     = 16'd20000;

    // minutes at which a trim check runs
    localparam logic [5:0] TRIM_MIN_A = 6'd20;
    localparam logic [5:0] TRIM_MIN_B = 6'd50;

    // last trim hour before any trim
    localparam logic [6:0] HOUR_NEVER = 7'd90;

    // tube code that stands for a zero in the hours tens place
    localparam logic [3:0] ZERO_CODE = 4'd10;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DIM_START = 2'd0,
        CFG_DIM_END   = 2'd1,
        CFG_XFADE     = 2'd2
    } cfg_index_t;

    // one display update as held in the input register
    typedef struct packed {
        logic [4:0] soft_hours;
        logic [5:0] soft_minutes;
        logic [5:0] soft_seconds;
        logic [4:0] rtc_hours;
        logic [5:0] rtc_minutes;
        logic [5:0] rtc_seconds;
    } item_t;

endpackage

@@ design/clock_display_drift_trim_top.sv @@
// channel | direction | handshake            | payload
// in      | in        | in_valid / in_stall  | soft_* and rtc_* time fields
// out     | out       | out_valid / out_stall| four digits, use_crossfade, dim_on,
//         |           |                      | tick_limit_out
// cfg     | in        | cfg_we               | cfg_index, cfg_data (no read-back)
//
// an item waits in the input register and moves on into the output register
// when that one is free; one item per cycle is sustained while out_stall is
// low, with the trim adder chain combinational between the two registers
// rst_n is asynchronous and active low; it clears both valid flags, the tick
// limit (to 31250) and both last-trim hours (to "never"), and the config registers
// a stalled output holds its item while the input register can still take one
// more; in_stall rises only when both registers are full and out_stall is high
module clock_display_drift_trim_top (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [4:0]  soft_hours,
    input  logic [5:0]  soft_minutes,
    input  logic [5:0]  soft_seconds,
    input  logic [4:0]  rtc_hours,
    input  logic [5:0]  rtc_minutes,
    input  logic [5:0]  rtc_seconds,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  hour_tens_digit,
    output logic [3:0]  hour_ones_digit,
    output logic [2:0]  minute_tens_digit,
    output logic [3:0]  minute_ones_digit,
    output logic        use_crossfade,
    output logic        dim_on,
    output logic [15:0] tick_limit_out,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);

    // configuration registers
    logic [4:0] dim_start_reg;
    logic [4:0] dim_end_reg;
    logic       xfade_reg;

    // trim state
    logic [15:0] tick_limit_reg;
    logic [15:0] tick_limit_next;
    logic [6:0]  last20_reg;
    logic [6:0]  last50_reg;

    // input register
    cddt_pkg::item_t s1_item_reg;
    logic            s1_valid_reg;

    // result register
    logic        out_valid_reg;
    logic [3:0]  hour_tens_reg;
    logic [3:0]  hour_ones_reg;
    logic [2:0]  minute_tens_reg;
    logic [3:0]  minute_ones_reg;
    logic        xfade_out_reg;
    logic        dim_reg;

    // handshake
    logic out_free;
    logic s1_fire;
    logic in_fire;

    // per-item logic
    logic [1:0]  hr_tens;
    logic [2:0]  mn_tens;
    logic [4:0]  hr_tens_x10;
    logic [5:0]  mn_tens_x10;
    logic [4:0]  hr_ones;
    logic [5:0]  mn_ones;
    logic        hit20;
    logic        hit50;
    logic        trim_hit;
    logic [4:0]  dim_hour;
    logic        dim_next;
    logic [15:0] sec_diff;
    logic [15:0] min_diff;
    logic [15:0] min_secs;
    logic [15:0] diff_secs;
    logic [15:0] trim_step;
    logic [15:0] trimmed;

    // output register frees up when empty or taken this cycle
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_start_reg <= 5'd0;
            dim_end_reg   <= 5'd0;
            xfade_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cddt_pkg::CFG_DIM_START: dim_start_reg <= cfg_data;
                cddt_pkg::CFG_DIM_END:   dim_end_reg   <= cfg_data;
                cddt_pkg::CFG_XFADE:     xfade_reg     <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.soft_hours   <= soft_hours;
            s1_item_reg.soft_minutes <= soft_minutes;
            s1_item_reg.soft_seconds <= soft_seconds;
            s1_item_reg.rtc_hours    <= rtc_hours;
            s1_item_reg.rtc_minutes  <= rtc_minutes;
            s1_item_reg.rtc_seconds  <= rtc_seconds;
        end
    end

    // digit split: tens by compare, ones by subtracting tens times ten
    always_comb
    begin
        if (s1_item_reg.soft_hours >= 5'd30)
            hr_tens = 2'd3;
        else if (s1_item_reg.soft_hours >= 5'd20)
            hr_tens = 2'd2;
        else if (s1_item_reg.soft_hours >= 5'd10)
            hr_tens = 2'd1;
        else
            hr_tens = 2'd0;

        if (s1_item_reg.soft_minutes >= 6'd60)
            mn_tens = 3'd6;
        else if (s1_item_reg.soft_minutes >= 6'd50)
            mn_tens = 3'd5;
        else if (s1_item_reg.soft_minutes >= 6'd40)
            mn_tens = 3'd4;
        else if (s1_item_reg.soft_minutes >= 6'd30)
            mn_tens = 3'd3;
        else if (s1_item_reg.soft_minutes >= 6'd20)
            mn_tens = 3'd2;
        else if (s1_item_reg.soft_minutes >= 6'd10)
            mn_tens = 3'd1;
        else
            mn_tens = 3'd0;
    end

    assign hr_tens_x10 = {hr_tens, 3'b000} + {2'b00, hr_tens, 1'b0};
    assign mn_tens_x10 = {mn_tens, 3'b000} + {2'b00, mn_tens, 1'b0};
    assign hr_ones     = s1_item_reg.soft_hours - hr_tens_x10;
    assign mn_ones     = s1_item_reg.soft_minutes - mn_tens_x10;

    // trim check, once per hour at each of the two minutes
    assign hit20 = (s1_item_reg.soft_minutes == cddt_pkg::TRIM_MIN_A)
                && (last20_reg != {2'b00, s1_item_reg.soft_hours});
    assign hit50 = (s1_item_reg.soft_minutes == cddt_pkg::TRIM_MIN_B)
                && (last50_reg != {2'b00, s1_item_reg.soft_hours});
    assign trim_hit = hit20 || hit50;

    // drift in seconds, all modulo 2^16; times 60 and times 18 as shift-adds
    assign sec_diff  = {10'd0, s1_item_reg.rtc_seconds} - {10'd0, s1_item_reg.soft_seconds};
    assign min_diff  = {10'd0, s1_item_reg.rtc_minutes} - {10'd0, s1_item_reg.soft_minutes};
    assign min_secs  = (min_diff << 6) - (min_diff << 2);
    assign diff_secs = sec_diff + min_secs;
    assign trim_step = (diff_secs << 4) + (diff_secs << 1);
    assign trimmed   = tick_limit_reg - trim_step;

    always_comb
    begin
        tick_limit_next = tick_limit_reg;
        if (trim_hit)
        begin
            if (s1_item_reg.rtc_hours != s1_item_reg.soft_hours)
                tick_limit_next = cddt_pkg::LIMIT_DEFAULT;
            else if (trimmed > cddt_pkg::LIMIT_MAX || trimmed < cddt_pkg::LIMIT_MIN)
                tick_limit_next = cddt_pkg::LIMIT_DEFAULT;
            else
                tick_limit_next = trimmed;
        end
    end

    // dim window, wrapping past midnight when end is below start
    assign dim_hour = trim_hit ? s1_item_reg.rtc_hours : s1_item_reg.soft_hours;

    always_comb
    begin
        if (dim_end_reg >= dim_start_reg)
            dim_next = (dim_hour >= dim_start_reg) && (dim_hour < dim_end_reg);
        else
            dim_next = !((dim_hour >= dim_end_reg) && (dim_hour < dim_start_reg));
    end

    // trim state moves with the item into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_limit_reg <= cddt_pkg::LIMIT_DEFAULT;
            last20_reg     <= cddt_pkg::HOUR_NEVER;
            last50_reg     <= cddt_pkg::HOUR_NEVER;
        end
        else if (s1_fire)
        begin
            tick_limit_reg <= tick_limit_next;
            if (hit20)
                last20_reg <= {2'b00, s1_item_reg.soft_hours};
            if (hit50)
                last50_reg <= {2'b00, s1_item_reg.soft_hours};
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            hour_tens_reg   <= (hr_tens == 2'd0) ? cddt_pkg::ZERO_CODE : {2'b00, hr_tens};
            hour_ones_reg   <= hr_ones[3:0];
            minute_tens_reg <= mn_tens;
            minute_ones_reg <= mn_ones[3:0];
            xfade_out_reg   <= xfade_reg;
            dim_reg         <= dim_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign hour_tens_digit   = hour_tens_reg;
    assign hour_ones_digit   = hour_ones_reg;
    assign minute_tens_digit = minute_tens_reg;
    assign minute_ones_digit = minute_ones_reg;
    assign use_crossfade     = xfade_out_reg;
    assign dim_on            = dim_reg;
    // tick limit register only changes when the item leaves for the output
    assign tick_limit_out    = tick_limit_reg;

    // the tick limit always stays within its legal band
    assert property (@(posedge clk) disable iff (!rst_n)
        (tick_limit_reg >= cddt_pkg::LIMIT_MIN) && (tick_limit_reg <= cddt_pkg::LIMIT_MAX))
        else $error("tick limit out of band");

    // stall toward the source only when both registers hold an item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room to spare");

    // a held item is not dropped while the output is blocked
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && out_stall) |=> s1_valid_reg)
        else $error("item lost under stall");

    // a trim at minute 20 records its hour
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && hit20) |=> (last20_reg == $past({2'b00, s1_item_reg.soft_hours})))
        else $error("minute 20 trim hour not recorded");

    // a trim at minute 50 records its hour
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && hit50) |=> (last50_reg == $past({2'b00, s1_item_reg.soft_hours})))
        else $error("minute 50 trim hour not recorded");

endmodule

@@ sim/tb_clock_display_drift_trim_top.sv @@
module tb_clock_display_drift_trim_top;
    timeunit 1ns;
    timeprecision 1ps;

    // half clock period, reset length and how long the run may sit without any handshake
    localparam int CLK_HALF_NS    = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int PIPE_LATENCY   = 2;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_CAP      = 50;

    // trim arithmetic: ticks removed per second of drift, seconds per minute
    localparam int TICKS_PER_SEC = 18;
    localparam int SECS_PER_MIN  = 60;

    typedef cddt_pkg::item_t update_t;

    // one display result as it leaves the block
    typedef struct packed {
        logic [3:0]  hour_tens_digit;
        logic [3:0]  hour_ones_digit;
        logic [2:0]  minute_tens_digit;
        logic [3:0]  minute_ones_digit;
        logic        use_crossfade;
        logic        dim_on;
        logic [15:0] tick_limit_out;
    } display_t;

    logic        clk;
    logic        rst_n;

    // input channel
    logic        in_valid;
    logic        in_stall;
    update_t     drive_item;

    // output channel
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  hour_tens_digit;
    logic [3:0]  hour_ones_digit;
    logic [2:0]  minute_tens_digit;
    logic [3:0]  minute_ones_digit;
    logic        use_crossfade;
    logic        dim_on;
    logic [15:0] tick_limit_out;
    display_t    seen_display;

    // configuration write port
    logic                 cfg_we;
    cddt_pkg::cfg_index_t cfg_index;
    logic [4:0]           cfg_data;

    // copy of the block's settings and trim state, advanced at each accepted item
    logic [4:0]  dim_start;
    logic [4:0]  dim_end;
    logic        xfade_on;
    logic [15:0] trim_limit;
    logic [6:0]  last_hour_20;
    logic [6:0]  last_hour_50;

    // displays predicted for accepted items, oldest first
    display_t    pending_displays[$];

    int          error_count;
    int          results_seen;
    int          idle_cycles;

    // idling odds in percent, set per phase
    int          send_idle_pct;
    int          recv_stall_pct;

    // long receiver hold-off: the test sets the length and flips the kick bit
    int          hold_len;
    logic        hold_kick;
    logic        hold_seen;
    int          hold_left;

    clock_display_drift_trim_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .soft_hours        (drive_item.soft_hours),
        .soft_minutes      (drive_item.soft_minutes),
        .soft_seconds      (drive_item.soft_seconds),
        .rtc_hours         (drive_item.rtc_hours),
        .rtc_minutes       (drive_item.rtc_minutes),
        .rtc_seconds       (drive_item.rtc_seconds),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .hour_tens_digit   (hour_tens_digit),
        .hour_ones_digit   (hour_ones_digit),
        .minute_tens_digit (minute_tens_digit),
        .minute_ones_digit (minute_ones_digit),
        .use_crossfade     (use_crossfade),
        .dim_on            (dim_on),
        .tick_limit_out    (tick_limit_out),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    assign seen_display = {hour_tens_digit, hour_ones_digit, minute_tens_digit,
                           minute_ones_digit, use_crossfade, dim_on, tick_limit_out};

    always #(CLK_HALF_NS) clk = ~clk;

    // predicted display for one update; advances the trim state as the block does
    function automatic display_t predict_display(input update_t u);
        display_t    d;
        logic [4:0]  dim_hour;
        logic [4:0]  hour_tens;
        logic        hit_20;
        logic        hit_50;
        int          drift;
        int          trim_step;
        logic [15:0] lim;
        dim_hour = u.soft_hours;
        hit_20 = (u.soft_minutes == cddt_pkg::TRIM_MIN_A)
              && ({2'b00, u.soft_hours} != last_hour_20);
        hit_50 = (u.soft_minutes == cddt_pkg::TRIM_MIN_B)
              && ({2'b00, u.soft_hours} != last_hour_50);
        if (hit_20 || hit_50)
        begin
            if (u.soft_minutes == cddt_pkg::TRIM_MIN_A)
                last_hour_20 = {2'b00, u.soft_hours};
            if (u.soft_minutes == cddt_pkg::TRIM_MIN_B)
                last_hour_50 = {2'b00, u.soft_hours};
            // during a trim check the rtc hour drives dimming, even on an hour mismatch
            dim_hour = u.rtc_hours;
            if (u.rtc_hours != u.soft_hours)
                trim_limit = cddt_pkg::LIMIT_DEFAULT;
            else
            begin
                drift = (int'(u.rtc_seconds) - int'(u.soft_seconds))
                      + SECS_PER_MIN * (int'(u.rtc_minutes) - int'(u.soft_minutes));
                trim_step = TICKS_PER_SEC * drift;
                lim = trim_limit - trim_step[15:0];
                if (lim > cddt_pkg::LIMIT_MAX || lim < cddt_pkg::LIMIT_MIN)
                    lim = cddt_pkg::LIMIT_DEFAULT;
                trim_limit = lim;
            end
        end
        hour_tens = 5'(u.soft_hours / 10);
        d.hour_tens_digit   = (hour_tens != 0) ? hour_tens[3:0] : cddt_pkg::ZERO_CODE;
        d.hour_ones_digit   = 4'(u.soft_hours % 10);
        d.minute_tens_digit = 3'(u.soft_minutes / 10);
        d.minute_ones_digit = 4'(u.soft_minutes % 10);
        d.use_crossfade     = xfade_on;
        // plain window when end >= start, otherwise it wraps past midnight
        if (dim_end >= dim_start)
            d.dim_on = (dim_hour >= dim_start) && (dim_hour < dim_end);
        else
            d.dim_on = !((dim_hour >= dim_end) && (dim_hour < dim_start));
        d.tick_limit_out = trim_limit;
        return d;
    endfunction

    function automatic update_t timestamp(input int sh, input int sm, input int ss,
                                          input int rh, input int rm, input int rs);
        update_t u;
        u.soft_hours   = 5'(sh);
        u.soft_minutes = 6'(sm);
        u.soft_seconds = 6'(ss);
        u.rtc_hours    = 5'(rh);
        u.rtc_minutes  = 6'(rm);
        u.rtc_seconds  = 6'(rs);
        return u;
    endfunction

    // mostly clock-like updates clustered on the trim minutes with a small rtc drift,
    // the rest raw noise over the full field widths
    function automatic update_t random_update();
        update_t u;
        int      sm;
        int      pick;
        if ($urandom_range(0, 99) < 25)
        begin
            u = update_t'(34'({$urandom, $urandom}));
            return u;
        end
        pick = $urandom_range(0, 9);
        if (pick < 4)
            sm = int'(cddt_pkg::TRIM_MIN_A);
        else if (pick < 8)
            sm = int'(cddt_pkg::TRIM_MIN_B);
        else
            sm = $urandom_range(0, 59);
        u.soft_hours   = 5'($urandom_range(0, 23));
        u.soft_minutes = 6'(sm);
        u.soft_seconds = 6'($urandom_range(0, 59));
        // rtc hour mostly agrees, sometimes not
        u.rtc_hours    = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 23))
                                                     : u.soft_hours;
        u.rtc_minutes  = 6'((sm + 59 + $urandom_range(0, 2)) % 60);
        u.rtc_seconds  = 6'($urandom_range(0, 59));
        return u;
    endfunction

    task automatic report_mismatch(input string what, input int got_val, input int want_val);
        if (error_count < PRINT_CAP)
            $display("mismatch on result %0d, %s: got %0d, expected %0d",
                     results_seen, what, got_val, want_val);
        error_count++;
    endtask

    // offer one update, idling first at the sender's odds, and hold it until taken
    task automatic send_update(input update_t u);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        drive_item <= u;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_displays.push_back(predict_display(u));
    endtask

    // stop offering, let every predicted display come out and the pipe settle
    task automatic drain_displays();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_displays.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    task automatic write_register(input cddt_pkg::cfg_index_t idx, input logic [4:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        case (idx)
            cddt_pkg::CFG_DIM_START: dim_start = value;
            cddt_pkg::CFG_DIM_END:   dim_end   = value;
            cddt_pkg::CFG_XFADE:     xfade_on  = value[0];
            default:                 ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // only called with the block idle
    task automatic set_display_config(input int start_hour, input int end_hour,
                                      input int xfade);
        write_register(cddt_pkg::CFG_DIM_START, 5'(start_hour));
        write_register(cddt_pkg::CFG_DIM_END, 5'(end_hour));
        write_register(cddt_pkg::CFG_XFADE, 5'(xfade));
    endtask

    // digit extremes, both trim minutes, repeat in the same hour, hour mismatch,
    // limit below the floor, wrap of the 16-bit limit, odd times
    task automatic test_digits_and_trim();
        send_update(timestamp(0, 0, 0, 0, 0, 0));
        send_update(timestamp(9, 59, 59, 9, 59, 59));
        send_update(timestamp(10, 5, 30, 10, 5, 30));
        send_update(timestamp(23, 59, 59, 23, 59, 59));
        // first trim ever, rtc a few seconds ahead
        send_update(timestamp(12, 20, 0, 12, 20, 5));
        // same slot, same hour: no second trim
        send_update(timestamp(12, 20, 30, 12, 20, 0));
        // rtc behind, limit grows
        send_update(timestamp(12, 50, 10, 12, 49, 50));
        // hours disagree: limit back to default
        send_update(timestamp(13, 20, 0, 14, 20, 0));
        // big drift, still in range
        send_update(timestamp(13, 50, 0, 13, 59, 59));
        // drops below the floor
        send_update(timestamp(14, 20, 0, 14, 20, 30));
        // large negative drift wraps the 16-bit limit back into range
        send_update(timestamp(14, 50, 59, 14, 0, 0));
        // rtc fields at their top, limit wraps back into range
        send_update(timestamp(15, 20, 0, 15, 63, 63));
        // hours and minutes beyond a real clock, all ones
        send_update(timestamp(24, 20, 0, 24, 20, 10));
        send_update(timestamp(31, 63, 63, 31, 63, 63));
        send_update(timestamp(30, 60, 0, 30, 60, 0));
        drain_displays();
    endtask

    // dim window both plain and wrapped, rtc hour deciding dim during a trim check
    task automatic test_dim_window();
        set_display_config(22, 6, 1);
        send_update(timestamp(21, 10, 0, 21, 10, 0));
        send_update(timestamp(22, 10, 0, 22, 10, 0));
        send_update(timestamp(5, 59, 0, 5, 59, 0));
        send_update(timestamp(6, 0, 0, 6, 0, 0));
        // soft hour outside the window, rtc hour inside
        send_update(timestamp(7, 50, 0, 23, 50, 0));
        // soft hour inside the window, rtc hour outside
        send_update(timestamp(3, 20, 0, 12, 20, 0));
        drain_displays();
        set_display_config(8, 17, 0);
        send_update(timestamp(8, 0, 0, 8, 0, 0));
        send_update(timestamp(16, 59, 0, 16, 59, 0));
        send_update(timestamp(17, 0, 0, 17, 0, 0));
        send_update(timestamp(7, 59, 0, 7, 59, 0));
        drain_displays();
    endtask

    // a spread of settings, extremes and out-of-range hours among them
    task automatic test_config_sweep();
        int start_hours[8] = '{0, 22, 8, 23, 31, 0, 5, 31};
        int end_hours[8]   = '{0, 6, 17, 0, 31, 31, 5, 0};
        int xfades[8]      = '{0, 1, 0, 1, 1, 0, 1, 0};
        for (int s = 0; s < 8; s++)
        begin
            set_display_config(start_hours[s], end_hours[s], xfades[s]);
            repeat (40) send_update(random_update());
            drain_displays();
        end
    endtask

    // three idling phases, fresh random settings for each
    task automatic test_random_traffic();
        int sender_odds[3]   = '{27, 88, 0};
        int receiver_odds[3] = '{88, 27, 0};
        for (int p = 0; p < 3; p++)
        begin
            send_idle_pct  = sender_odds[p];
            recv_stall_pct = receiver_odds[p];
            set_display_config($urandom_range(0, 23), $urandom_range(0, 23),
                               $urandom_range(0, 1));
            repeat (500) send_update(random_update());
            drain_displays();
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so both registers fill and in_stall must rise
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 60;
        hold_kick      = ~hold_kick;
        repeat (40) send_update(random_update());
        drain_displays();
    endtask

    // receiver stall, random or a requested hold-off
    always @(negedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen = hold_kick;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // every accepted display against the oldest prediction, field by field
    always @(posedge clk)
    begin
        display_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_displays.size() == 0)
                report_mismatch("display with nothing expected", 0, 0);
            else
            begin
                want = pending_displays.pop_front();
                if (seen_display.hour_tens_digit !== want.hour_tens_digit)
                    report_mismatch("hour_tens_digit", int'(seen_display.hour_tens_digit),
                                    int'(want.hour_tens_digit));
                if (seen_display.hour_ones_digit !== want.hour_ones_digit)
                    report_mismatch("hour_ones_digit", int'(seen_display.hour_ones_digit),
                                    int'(want.hour_ones_digit));
                if (seen_display.minute_tens_digit !== want.minute_tens_digit)
                    report_mismatch("minute_tens_digit",
                                    int'(seen_display.minute_tens_digit),
                                    int'(want.minute_tens_digit));
                if (seen_display.minute_ones_digit !== want.minute_ones_digit)
                    report_mismatch("minute_ones_digit",
                                    int'(seen_display.minute_ones_digit),
                                    int'(want.minute_ones_digit));
                if (seen_display.use_crossfade !== want.use_crossfade)
                    report_mismatch("use_crossfade", int'(seen_display.use_crossfade),
                                    int'(want.use_crossfade));
                if (seen_display.dim_on !== want.dim_on)
                    report_mismatch("dim_on", int'(seen_display.dim_on),
                                    int'(want.dim_on));
                if (seen_display.tick_limit_out !== want.tick_limit_out)
                    report_mismatch("tick_limit_out", int'(seen_display.tick_limit_out),
                                    int'(want.tick_limit_out));
            end
        end
    end

    // watchdog: cycles without any handshake or register write
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        // every input known from time zero, reset held low
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        drive_item     = '0;
        out_stall      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = cddt_pkg::CFG_DIM_START;
        cfg_data       = '0;
        dim_start      = '0;
        dim_end        = '0;
        xfade_on       = 1'b0;
        trim_limit     = cddt_pkg::LIMIT_DEFAULT;
        last_hour_20   = cddt_pkg::HOUR_NEVER;
        last_hour_50   = cddt_pkg::HOUR_NEVER;
        error_count    = 0;
        results_seen   = 0;
        idle_cycles    = 0;
        send_idle_pct  = 27;
        recv_stall_pct = 88;
        hold_len       = 0;
        hold_kick      = 1'b0;
        hold_seen      = 1'b0;
        hold_left      = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_digits_and_trim();
        test_dim_window();
        test_config_sweep();
        test_random_traffic();
        test_backpressure();

        // let any stray result show up before the verdict
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
